>>> hw/rtl/rc4_pkg.sv
package rc4_pkg;

	localparam int KEY_MAX = 256;
	localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int KEY_CW = $clog2(KEY_MAX + 1);

	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW = 8;

	// item selector carried on tuser
	localparam logic [1:0] MODE_KEY  = 2'd0;
	localparam logic [1:0] MODE_SKIP = 2'd1;
	localparam logic [1:0] MODE_DATA = 2'd2;

	// what the running step sequence belongs to
	localparam logic [1:0] KIND_KSA  = 2'd0;
	localparam logic [1:0] KIND_SKIP = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_JREAD = 3'd2;
	localparam logic [2:0] ST_SWAP  = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic                 en;
		logic [PERM_AW-1:0]   addr;
	} perm_rd_t;

	typedef struct packed {
		logic                 en;
		logic [PERM_AW-1:0]   addr;
		byte_t                data;
	} perm_wr_t;

endpackage

>>> hw/rtl/rc4_perm_store.sv
module rc4_perm_store (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  rc4_pkg::perm_rd_t rd_a,
	input  rc4_pkg::perm_rd_t rd_b,
	input  rc4_pkg::perm_wr_t wr,
	output rc4_pkg::byte_t    rd_a_data,
	output rc4_pkg::byte_t    rd_b_data
);
	import rc4_pkg::*;

	byte_t                  mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0]  valid_q;
	byte_t                  a_data_s1, b_data_s1;
	logic [PERM_AW-1:0]     a_addr_s1, b_addr_s1;
	logic                   a_valid_s1, b_valid_s1;

	// old data on a read of the entry being written
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_a.en) begin
			a_data_s1 <= mem[rd_a.addr];
			a_addr_s1 <= rd_a.addr;
		end
		if (rd_b.en) begin
			b_data_s1 <= mem[rd_b.addr];
			b_addr_s1 <= rd_b.addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			a_valid_s1 <= 1'b0;
			b_valid_s1 <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_a.en) begin
				a_valid_s1 <= valid_q[rd_a.addr];
			end
			if (rd_b.en) begin
				b_valid_s1 <= valid_q[rd_b.addr];
			end
		end
	end

	// an entry never written since the last clear holds the identity
	assign rd_a_data = a_valid_s1 ? a_data_s1 : byte_t'(a_addr_s1);
	assign rd_b_data = b_valid_s1 ? b_data_s1 : byte_t'(b_addr_s1);

endmodule

>>> hw/rtl/rc4_stream_cipher_core.sv
// rc4 engine: key load, key schedule, keystream skip and data transform.
// data byte: result registered via the jread, swap and out states after its transfer; a
// new data byte waits until the last is through the read / read / swap sequence on the
// permutation memory and its result is not stalled. final key byte: runs the key schedule.
// skip of n steps: n keystream steps with no output. reset: asynchronous, no sweep of memory.
module rc4_stream_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // in_byte [7:0], skip_count [23:8]
	input  logic [1:0]  s_tuser,   // mode
	input  logic        s_tlast,   // key_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // out_byte
);
	import rc4_pkg::*;

	logic [2:0]         state_q;
	logic [1:0]         kind_q;
	byte_t              i_q, j_q;
	logic [15:0]        rem_q;
	logic [KEY_CW-1:0]  key_count_q, len_q;
	logic [KEY_AW-1:0]  k_q;
	logic               fwd_s1;
	byte_t              fwd_val_s1, key_data_s1;
	byte_t              si_q, sj_q, t_q, byte_q;
	logic               m_tvalid_q;
	byte_t              m_tdata_q;

	byte_t              key_mem [KEY_MAX];

	logic [1:0]         in_mode;
	byte_t              in_byte;
	logic [15:0]        in_skip;
	logic               accept, can_out, out_stall, ksa_end, step_done, cont, issue;
	logic               step_item, ksa_start, key_room;
	logic [KEY_CW-1:0]  key_len, k_inc;
	byte_t              i_next, si_eff, j_sum, t_addr, ks;

	perm_rd_t           rd_a, rd_b;
	perm_wr_t           wr;
	byte_t              rd_a_data, rd_b_data;

	assign in_mode = s_tuser;
	assign in_byte = s_tdata[7:0];
	assign in_skip = s_tdata[23:8];

	assign accept    = s_tvalid && s_tready;
	assign can_out   = !m_tvalid_q || m_tready;
	assign out_stall = (state_q == ST_OUT) && (kind_q == KIND_DATA) && !can_out;
	assign ksa_end   = (state_q == ST_OUT) && (kind_q == KIND_KSA) && (i_q == 8'hFF);
	assign step_done = (state_q == ST_OUT) &&
		((kind_q == KIND_DATA) || ((kind_q == KIND_SKIP) && (rem_q == 16'd1)));
	assign cont      = (state_q == ST_OUT) && !step_done && !ksa_end;
	assign s_tready  = (state_q == ST_IDLE) || (step_done && !out_stall);

	assign step_item = accept &&
		(((in_mode == MODE_SKIP) && (in_skip != 16'd0)) || (in_mode == MODE_DATA));
	assign ksa_start = accept && (in_mode == MODE_KEY) && s_tlast;
	assign issue     = step_item || cont || (state_q == ST_ISSUE);

	assign key_room = key_count_q < KEY_CW'(KEY_MAX);
	assign key_len  = key_count_q + KEY_CW'(key_room);
	assign k_inc    = KEY_CW'(k_q) + KEY_CW'(1);

	assign i_next = i_q + 8'd1;
	// the entry at the next i may still be in flight from the swap write
	assign si_eff = fwd_s1 ? fwd_val_s1 : rd_a_data;
	assign j_sum  = j_q + si_eff + ((kind_q == KIND_KSA) ? key_data_s1 : 8'd0);
	assign t_addr = si_q + rd_a_data;
	assign ks     = (t_q == i_q) ? sj_q : ((t_q == j_q) ? si_q : rd_b_data);

	always_comb begin
		rd_a.en   = issue || (state_q == ST_JREAD);
		rd_a.addr = (state_q == ST_JREAD) ? j_sum : i_next;
		rd_b.en   = (state_q == ST_SWAP);
		rd_b.addr = t_addr;
		wr.en     = (state_q == ST_SWAP) || ((state_q == ST_OUT) && !out_stall);
		wr.addr   = (state_q == ST_SWAP) ? i_q : j_q;
		wr.data   = (state_q == ST_SWAP) ? rd_a_data : si_q;
	end

	rc4_perm_store u_perm (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (ksa_start),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.wr        (wr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	always_ff @(posedge clk) begin
		if (accept && (in_mode == MODE_KEY) && key_room) begin
			key_mem[key_count_q[KEY_AW-1:0]] <= in_byte;
		end
		key_data_s1 <= key_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_SKIP;
			i_q         <= '0;
			j_q         <= '0;
			rem_q       <= '0;
			key_count_q <= '0;
			len_q       <= KEY_CW'(1);
			k_q         <= '0;
			fwd_s1      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ksa_start) begin
						state_q <= ST_ISSUE;
					end else if (step_item) begin
						state_q <= ST_JREAD;
					end
				end
				ST_ISSUE: state_q <= ST_JREAD;
				ST_JREAD: state_q <= ST_SWAP;
				ST_SWAP:  state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_stall) begin
						if (cont || step_item) begin
							state_q <= ST_JREAD;
						end else if (ksa_start) begin
							state_q <= ST_ISSUE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (issue) begin
				i_q <= i_next;
			end
			if (state_q == ST_JREAD) begin
				j_q <= j_sum;
			end
			if (ksa_start) begin
				i_q <= 8'hFF;
				j_q <= '0;
			end
			if (ksa_end) begin
				i_q <= '0;
				j_q <= '0;
			end

			if (ksa_start) begin
				kind_q <= KIND_KSA;
			end else if (step_item) begin
				kind_q <= (in_mode == MODE_DATA) ? KIND_DATA : KIND_SKIP;
			end

			if (step_item) begin
				rem_q <= in_skip;
			end else if (cont && (kind_q == KIND_SKIP)) begin
				rem_q <= rem_q - 16'd1;
			end

			if (accept && (in_mode == MODE_KEY)) begin
				if (s_tlast) begin
					key_count_q <= '0;
				end else if (key_room) begin
					key_count_q <= key_count_q + KEY_CW'(1);
				end
			end

			// key index wraps at the loaded key length
			if (ksa_start) begin
				len_q <= key_len;
				k_q   <= '0;
			end else if (issue && (kind_q == KIND_KSA)) begin
				k_q <= (k_inc >= len_q) ? '0 : k_inc[KEY_AW-1:0];
			end

			fwd_s1 <= (state_q == ST_OUT) && (i_next == j_q);

			if ((state_q == ST_OUT) && (kind_q == KIND_DATA) && !out_stall) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_val_s1 <= si_q;
		if (state_q == ST_JREAD) begin
			si_q <= si_eff;
		end
		if (state_q == ST_SWAP) begin
			sj_q <= rd_a_data;
			t_q  <= t_addr;
		end
		if (accept) begin
			byte_q <= in_byte;
		end
		if ((state_q == ST_OUT) && (kind_q == KIND_DATA) && !out_stall) begin
			m_tdata_q <= byte_q ^ ks;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/rc4_sva_checker.sv
module rc4_sva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);
	import rc4_pkg::*;

	logic s_xfer;
	assign s_xfer = s_tvalid && s_tready;

	// held result stays put until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// final key byte starts the schedule, so no transfer can follow at once
	a_ksa_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && (s_tuser == MODE_KEY) && s_tlast |=> !s_tready)
		else $error("input taken during key schedule");

	// a plain key byte does not hold off the input
	a_key_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && (s_tuser == MODE_KEY) && !s_tlast |=> s_tready)
		else $error("key byte did not complete in one cycle");

	// a keystream step needs the permutation read sequence
	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && (s_tuser == MODE_DATA) |=> !s_tready)
		else $error("input taken during keystream step");

endmodule

bind rc4_stream_cipher_core rc4_sva_checker u_rc4_sva_checker (.*);
